@@ rtl/tbb_pkg.sv @@
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared constants for the transformed bounding box block: field widths,
// command and result codes, register indexes and coefficient reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tbb_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_W          = 16;
  localparam int FRAC_W          = 8;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int NUM_AXES        = 3;
  localparam int EDGE_POINTS     = 24;
  localparam int IDX_W           = $clog2(EDGE_POINTS);

  // Rounding constant: one half in the 8 fraction bits of the sum (Q26.8 at the default width).
  localparam logic [FRAC_W-1:0] RND_HALF = 8'h80;

  // Input command codes.
  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result kind codes.
  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_COLLIDE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 2'd2;

  // Axis codes, as found in the upper bits of the endpoint counter.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Identity transform after reset.
  localparam logic [CFG_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
  localparam logic [CFG_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
  localparam logic [CFG_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

endpackage

`default_nettype wire

@@ rtl/transformed_bounding_box_top.sv @@
// ----------------------------------------------------------------------------
// transformed_bounding_box_top
// Affine-transforms a stream of model vertices, keeps the running world-space
// bounding box of each batch, emits the box's edge endpoints at the end of
// a batch and answers box-overlap queries against the kept box.
//
//   Channel   Signals                                  Direction
//   in        in_valid/in_ready, in_cmd .. in_other_*  item in
//   out       out_valid/out_ready, out_kind .. last    item out
//   cfg       cfg_we, cfg_index, cfg_wdata             register write
//
// One item is accepted per cycle while in_ready is high. An item is held in
// the input register, where the transform, rounding, saturation and min/max
// update are done in one pass; the box is updated on the edge that commits it.
// A last vertex loads a snapshot of the box into the result register, which
// then sends every edge endpoint, one per cycle while out_ready is high; a query
// sends one item. Plain vertices keep flowing during that time; a query or
// a last vertex waits in the input register until the result register frees.
// Reset is synchronous, active low; it clears the box and loads identity rows.
// ----------------------------------------------------------------------------
`default_nettype none

module transformed_bounding_box_top #(
  parameter int COORD_WIDTH = tbb_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              cfg_we,
  input  wire logic [tbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tbb_pkg::CFG_W-1:0]         cfg_wdata,

  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_cmd,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vertex_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vertex_z,
  input  wire logic                              in_last_vertex,
  input  wire logic signed [COORD_WIDTH-1:0]     in_other_min_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_other_min_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_other_min_z,
  input  wire logic signed [COORD_WIDTH-1:0]     in_other_max_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_other_max_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_other_max_z,

  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_kind,
  output logic signed [COORD_WIDTH-1:0]          out_corner_x,
  output logic signed [COORD_WIDTH-1:0]          out_corner_y,
  output logic signed [COORD_WIDTH-1:0]          out_corner_z,
  output logic                                   out_colliding,
  output logic                                   out_last_result
);

  import tbb_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int PROD_W = CW + COEF_W;
  localparam int SUM_W  = CW + 18;
  localparam int HI_W   = SUM_W - (CW + FRAC_W - 1);

  // Configuration rows.
  logic [CFG_W-1:0] row_r [NUM_AXES];

  // Input register.
  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  logic                 s1_last_r;
  logic signed [CW-1:0] s1_vtx_r  [NUM_AXES];
  logic signed [CW-1:0] s1_omin_r [NUM_AXES];
  logic signed [CW-1:0] s1_omax_r [NUM_AXES];

  // Running box.
  logic                 batch_start_r, batch_start_nxt;
  logic signed [CW-1:0] box_min_r   [NUM_AXES];
  logic signed [CW-1:0] box_max_r   [NUM_AXES];
  logic signed [CW-1:0] box_min_nxt [NUM_AXES];
  logic signed [CW-1:0] box_max_nxt [NUM_AXES];

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  logic                 out_hit_r;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic signed [CW-1:0] snap_min_r [NUM_AXES];
  logic signed [CW-1:0] snap_max_r [NUM_AXES];

  // Datapath.
  logic signed [PROD_W-1:0] prod  [NUM_AXES][NUM_AXES];
  logic signed [SUM_W-1:0]  acc   [NUM_AXES];
  logic signed [CW-1:0]     world [NUM_AXES];
  logic                     hit;

  logic in_accept, needs_out, out_free, s1_commit, vtx_commit, load_out, out_done;
  logic sel_x, sel_y, sel_z;

  // --------------------------------------------------------------------------
  // Handshake and control
  // --------------------------------------------------------------------------
  assign in_accept  = in_valid && in_ready;
  assign needs_out  = (s1_cmd_r == CMD_QUERY) || s1_last_r;
  assign out_done   = out_valid_r && out_ready && out_last_result;
  assign out_free   = !out_valid_r || out_done;
  assign s1_commit  = s1_valid_r && (!needs_out || out_free);
  assign vtx_commit = s1_commit && (s1_cmd_r == CMD_VERTEX);
  assign load_out   = s1_commit && needs_out;
  assign in_ready   = !s1_valid_r || s1_commit;

  // --------------------------------------------------------------------------
  // Transform: three products per row, translation and rounding half added,
  // then the integer part of the sum (Q16.0 at the default width) is taken and saturated.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        prod[r][k] = s1_vtx_r[k] * $signed(row_r[r][k*COEF_W +: COEF_W]);
      end
      acc[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2])
             + SUM_W'($signed({row_r[r][NUM_AXES*COEF_W +: COEF_W], RND_HALF}));
      if (acc[r][SUM_W-1:CW+FRAC_W-1] == {HI_W{acc[r][SUM_W-1]}}) begin
        world[r] = acc[r][CW+FRAC_W-1:FRAC_W];
      end else if (acc[r][SUM_W-1]) begin
        world[r] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        world[r] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Box update and overlap test
  // --------------------------------------------------------------------------
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < NUM_AXES; k++) begin
      box_min_nxt[k] = box_min_r[k];
      box_max_nxt[k] = box_max_r[k];
      if (vtx_commit && (batch_start_r || world[k] < box_min_r[k])) begin
        box_min_nxt[k] = world[k];
      end
      if (vtx_commit && (batch_start_r || world[k] > box_max_r[k])) begin
        box_max_nxt[k] = world[k];
      end
      if (box_max_r[k] < s1_omin_r[k] || box_min_r[k] > s1_omax_r[k]) begin
        hit = 1'b0;
      end
    end
    batch_start_nxt = vtx_commit ? s1_last_r : batch_start_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = '0;
    end else if (out_done) begin
      out_valid_nxt = 1'b0;
    end else if (out_valid_r && out_ready) begin
      out_idx_nxt = out_idx_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_X_RESET;
      row_r[1] <= ROW_Y_RESET;
      row_r[2] <= ROW_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_X: row_r[0] <= cfg_wdata;
        CFG_ROW_Y: row_r[1] <= cfg_wdata;
        CFG_ROW_Z: row_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_idx_r     <= '0;
      batch_start_r <= 1'b1;
      for (int k = 0; k < NUM_AXES; k++) begin
        box_min_r[k] <= '0;
        box_max_r[k] <= '0;
      end
    end else begin
      s1_valid_r    <= in_accept || (s1_valid_r && !s1_commit);
      out_valid_r   <= out_valid_nxt;
      out_idx_r     <= out_idx_nxt;
      batch_start_r <= batch_start_nxt;
      box_min_r     <= box_min_nxt;
      box_max_r     <= box_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= in_cmd;
      s1_last_r    <= in_last_vertex;
      s1_vtx_r[0]  <= in_vertex_x;
      s1_vtx_r[1]  <= in_vertex_y;
      s1_vtx_r[2]  <= in_vertex_z;
      s1_omin_r[0] <= in_other_min_x;
      s1_omin_r[1] <= in_other_min_y;
      s1_omin_r[2] <= in_other_min_z;
      s1_omax_r[0] <= in_other_max_x;
      s1_omax_r[1] <= in_other_max_y;
      s1_omax_r[2] <= in_other_max_z;
    end
    if (load_out) begin
      out_kind_r <= (s1_cmd_r == CMD_QUERY) ? KIND_COLLIDE : KIND_EDGE;
      out_hit_r  <= hit;
      snap_min_r <= box_min_nxt;
      snap_max_r <= box_max_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Endpoint selection: counter bits 4:3 give the edge axis, bits 2:1 the
  // corner of the other two axes and bit 0 the low or high end.
  // --------------------------------------------------------------------------
  always_comb begin
    case (out_idx_r[IDX_W-1:IDX_W-2])
      AXIS_X: begin
        sel_x = out_idx_r[0];
        sel_y = out_idx_r[2];
        sel_z = out_idx_r[1];
      end
      AXIS_Y: begin
        sel_x = out_idx_r[2];
        sel_y = out_idx_r[0];
        sel_z = out_idx_r[1];
      end
      AXIS_Z: begin
        sel_x = out_idx_r[2];
        sel_y = out_idx_r[1];
        sel_z = out_idx_r[0];
      end
      default: begin
        sel_x = out_idx_r[0];
        sel_y = out_idx_r[2];
        sel_z = out_idx_r[1];
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_colliding   = (out_kind_r == KIND_COLLIDE) && out_hit_r;
  assign out_last_result = (out_kind_r == KIND_COLLIDE) ||
                           (out_idx_r == IDX_W'(EDGE_POINTS - 1));
  assign out_corner_x    = (out_kind_r != KIND_EDGE) ? '0 :
                           (sel_x ? snap_max_r[0] : snap_min_r[0]);
  assign out_corner_y    = (out_kind_r != KIND_EDGE) ? '0 :
                           (sel_y ? snap_max_r[1] : snap_min_r[1]);
  assign out_corner_z    = (out_kind_r != KIND_EDGE) ? '0 :
                           (sel_z ? snap_max_r[2] : snap_min_r[2]);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_idx_r < IDX_W'(EDGE_POINTS))
    else $error("endpoint counter beyond the last endpoint");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    box_min_r[0] <= box_max_r[0] && box_min_r[1] <= box_max_r[1] &&
    box_min_r[2] <= box_max_r[2])
    else $error("running box minimum above maximum");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_done |=> !out_valid_r || out_idx_r == '0)
    else $error("new result run does not start at the first item");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && needs_out && out_valid_r && !out_ready |-> !s1_commit && !in_ready)
    else $error("result-producing item committed while result register busy");

  a_stall_counter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_idx_r))
    else $error("endpoint counter moved during a stall");

endmodule

`default_nettype wire
